// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// when cond holds, expr must hold in the same cycle
`define ASSERT_IMPLY(lbl, ck, rs, cond, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |-> (expr)) \
    else $error("assertion failed");

// cond must never hold outside reset
`define ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, ck, rs, cond, expr)
`define ASSERT_NEVER(lbl, ck, rs, cond)

`endif

`endif

// ----- rtl/fvadv_pkg.sv -----
package fvadv_pkg;

  // value format: signed, VALUE_BITS wide, VALUE_BITS-4 fraction bits
  localparam int VALUE_BITS = 32;
  localparam int RATIO_BITS = 29;
  localparam int RATIO_SHIFT = 29;
  localparam int STAGE_BITS = 2;
  localparam int ORDER_BITS = 2;
  localparam int INDEX_BITS = 1;

  // width of the weighted stage sum and of the value before the final divide
  localparam int SUM_BITS = VALUE_BITS + 38;
  localparam int QUO_BITS = SUM_BITS - RATIO_SHIFT;

  // divide by three: dividend bits retired per pipeline stage
  localparam int DIGITS_PER_STAGE = 8;
  localparam int DIV_STAGES = (QUO_BITS + 1 + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;

  // register reset values and codes
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(134217728);
  localparam logic [ORDER_BITS-1:0] ORDER_FIRST = 2'd1;
  localparam logic [ORDER_BITS-1:0] ORDER_RESET = 2'd2;
  localparam logic [STAGE_BITS-1:0] RK_STAGE_ONE = 2'd1;
  localparam logic [STAGE_BITS-1:0] RK_STAGE_TWO = 2'd2;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_STEP_RATIO   = 1'b0,
    REG_SCHEME_ORDER = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] u_west2;
    logic signed [VALUE_BITS-1:0] u_west1;
    logic signed [VALUE_BITS-1:0] u_center;
    logic signed [VALUE_BITS-1:0] u_east1;
    logic signed [VALUE_BITS-1:0] u_south2;
    logic signed [VALUE_BITS-1:0] u_south1;
    logic signed [VALUE_BITS-1:0] u_north1;
    logic signed [VALUE_BITS-1:0] u_step_start;
    logic signed [VALUE_BITS-1:0] source_dt;
    logic [STAGE_BITS-1:0]        stage;
  } stencil_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] u_next;
    logic                         saturated;
  } update_t;

  // control travelling with a value into the divide pipeline
  typedef struct packed {
    logic valid;
    logic use_div;
  } div_ctl_t;

endpackage

// ----- rtl/fv_advection_cell_update_core.sv -----
// One cell update of a 2D upwind finite-volume advection step with minmod
// (or piecewise constant) faces and SSP Runge-Kutta stage weights, in signed
// fixed point with saturation. Fully pipelined: one stencil is taken on every
// cycle that start is high and busy is low, and its result appears on update
// with done high for exactly one cycle. The path runs through eight
// arithmetic stages (differences, faces, flux sums, split ratio multiply,
// inner value, stage weighting), the divide-by-three unit used by the third
// Runge-Kutta stage (input register, DIV_STAGES digit stages and bias
// removal register), and the saturation register. The receiver cannot
// stall: results are not held, so they must be taken in the cycle done is
// high. busy is high only around reset. Configuration writes are always
// accepted and must only be made while no items are in flight.
`include "assert_macros.svh"

module fv_advection_cell_update_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  fvadv_pkg::stencil_t                 stencil,
  output logic                                done,
  output fvadv_pkg::update_t                  update,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fvadv_pkg::INDEX_BITS-1:0]    cfg_index,
  input  logic [fvadv_pkg::RATIO_BITS-1:0]    cfg_data
);

  localparam int V = fvadv_pkg::VALUE_BITS;
  localparam int RB = fvadv_pkg::RATIO_BITS;
  localparam int RS = fvadv_pkg::RATIO_SHIFT;
  localparam int DW = V + 1;
  localparam int FW = V + 2;
  localparam int PDW = V + 3;
  localparam int DFW = V + 4;
  localparam int LO_BITS = DFW / 2;
  localparam int HI_BITS = DFW - LO_BITS;
  localparam int PL_BITS = LO_BITS + RB;
  localparam int PH_BITS = HI_BITS + RB + 1;
  localparam int PW = V + 34;
  localparam int IW = V + 35;
  localparam int SW = fvadv_pkg::SUM_BITS;
  localparam int QW = fvadv_pkg::QUO_BITS;
  localparam int LATENCY = 11 + fvadv_pkg::DIV_STAGES;

  localparam logic signed [SW-1:0] RND_S0 = SW'(1) << (RS - 1);
  localparam logic signed [SW-1:0] RND_S1 = SW'(1) << (RS + 1);
  localparam logic signed [SW-1:0] RND_S2 = SW'(3) << RS;
  localparam logic signed [V-1:0] VAL_MAX = {1'b0, {(V-1){1'b1}}};
  localparam logic signed [V-1:0] VAL_MIN = {1'b1, {(V-1){1'b0}}};

  // minmod: the smaller-magnitude slope when both agree in sign, else zero
  function automatic logic signed [DW-1:0] minmod(input logic signed [DW-1:0] back,
                                                  input logic signed [DW-1:0] fwd);
    logic signed [DW-1:0] pick;
    if (back == '0 || fwd == '0 || back[DW-1] != fwd[DW-1]) begin
      pick = '0;
    end else if (back[DW-1]) begin
      pick = (back < fwd) ? fwd : back;
    end else begin
      pick = (back < fwd) ? back : fwd;
    end
    return pick;
  endfunction

  logic [RB-1:0]                      step_ratio;
  logic [fvadv_pkg::ORDER_BITS-1:0]   scheme_order;
  logic                               accept;
  logic [7:0]                         pipe_valid;

  logic signed [V-1:0] in_w2, in_w1, in_c, in_e1, in_s2, in_s1, in_n1, in_old, in_src;

  // stage 1
  logic signed [DW-1:0] s1_dwa, s1_dwb, s1_deb, s1_dsa, s1_dsb, s1_dnb, s1_base;
  logic signed [V-1:0]  s1_w1, s1_c, s1_s1, s1_old;
  logic signed [FW-1:0] s1_old3;
  logic [fvadv_pkg::STAGE_BITS-1:0] s1_stage;
  // stage 2
  logic signed [DW-1:0] slope_w, slope_e, slope_s, slope_n;
  logic                 linear;
  logic signed [FW-1:0] s2_fw, s2_fe, s2_fs, s2_fn, s2_old3;
  logic signed [DW-1:0] s2_base;
  logic signed [V-1:0]  s2_old;
  logic [fvadv_pkg::STAGE_BITS-1:0] s2_stage;
  // stage 3
  logic signed [PDW-1:0] s3_dx, s3_dy;
  logic signed [DW-1:0]  s3_base;
  logic signed [FW-1:0]  s3_old3;
  logic signed [V-1:0]   s3_old;
  logic [fvadv_pkg::STAGE_BITS-1:0] s3_stage;
  // stage 4
  logic signed [DFW-1:0] s4_diff;
  logic signed [DW-1:0]  s4_base;
  logic signed [FW-1:0]  s4_old3;
  logic signed [V-1:0]   s4_old;
  logic [fvadv_pkg::STAGE_BITS-1:0] s4_stage;
  // stage 5
  logic [LO_BITS-1:0]        diff_lo;
  logic signed [HI_BITS-1:0] diff_hi;
  logic [PL_BITS-1:0]        s5_pl;
  logic signed [PH_BITS-1:0] s5_ph;
  logic signed [DW-1:0]      s5_base;
  logic signed [FW-1:0]      s5_old3;
  logic signed [V-1:0]       s5_old;
  logic [fvadv_pkg::STAGE_BITS-1:0] s5_stage;
  // stage 6
  logic signed [PW-1:0]  s6_prod;
  logic signed [DW-1:0]  s6_base;
  logic signed [FW-1:0]  s6_old3;
  logic signed [V-1:0]   s6_old;
  logic [fvadv_pkg::STAGE_BITS-1:0] s6_stage;
  // stage 7
  logic signed [IW-1:0]  s7_inner;
  logic signed [FW-1:0]  s7_old3;
  logic signed [V-1:0]   s7_old;
  logic [fvadv_pkg::STAGE_BITS-1:0] s7_stage;
  // stage 8
  logic signed [SW-1:0]  n0, n1, n2;
  logic signed [QW-1:0]  q_sel, s8_q;
  logic                  div_sel, s8_div;
  // divide and output
  fvadv_pkg::div_ctl_t   div_ctl;
  logic                  div_valid;
  logic signed [QW-1:0]  div_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= fvadv_pkg::RATIO_RESET;
      scheme_order <= fvadv_pkg::ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (fvadv_pkg::reg_index_t'(cfg_index))
        fvadv_pkg::REG_STEP_RATIO:   step_ratio <= cfg_data;
        fvadv_pkg::REG_SCHEME_ORDER: scheme_order <= cfg_data[fvadv_pkg::ORDER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // busy only while the pipeline is being cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // valid bits for the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else begin
      pipe_valid <= {pipe_valid[6:0], accept};
    end
  end

  assign in_w2 = stencil.u_west2;
  assign in_w1 = stencil.u_west1;
  assign in_c = stencil.u_center;
  assign in_e1 = stencil.u_east1;
  assign in_s2 = stencil.u_south2;
  assign in_s1 = stencil.u_south1;
  assign in_n1 = stencil.u_north1;
  assign in_old = stencil.u_step_start;
  assign in_src = stencil.source_dt;

  // stage 1: neighbor differences, center plus source, three times old value
  always_ff @(posedge clk) begin
    s1_dwa <= DW'(in_w1) - DW'(in_w2);
    s1_dwb <= DW'(in_c) - DW'(in_w1);
    s1_deb <= DW'(in_e1) - DW'(in_c);
    s1_dsa <= DW'(in_s1) - DW'(in_s2);
    s1_dsb <= DW'(in_c) - DW'(in_s1);
    s1_dnb <= DW'(in_n1) - DW'(in_c);
    s1_base <= DW'(in_c) + DW'(in_src);
    s1_old3 <= (FW'(in_old) <<< 1) + FW'(in_old);
    s1_w1 <= in_w1;
    s1_c <= in_c;
    s1_s1 <= in_s1;
    s1_old <= in_old;
    s1_stage <= stencil.stage;
  end

  // stage 2: limited slopes and doubled face states
  assign linear = (scheme_order != fvadv_pkg::ORDER_FIRST);
  assign slope_w = linear ? minmod(s1_dwa, s1_dwb) : '0;
  assign slope_e = linear ? minmod(s1_dwb, s1_deb) : '0;
  assign slope_s = linear ? minmod(s1_dsa, s1_dsb) : '0;
  assign slope_n = linear ? minmod(s1_dsb, s1_dnb) : '0;

  always_ff @(posedge clk) begin
    s2_fw <= (FW'(s1_w1) <<< 1) + FW'(slope_w);
    s2_fe <= (FW'(s1_c) <<< 1) + FW'(slope_e);
    s2_fs <= (FW'(s1_s1) <<< 1) + FW'(slope_s);
    s2_fn <= (FW'(s1_c) <<< 1) + FW'(slope_n);
    s2_base <= s1_base;
    s2_old3 <= s1_old3;
    s2_old <= s1_old;
    s2_stage <= s1_stage;
  end

  // stage 3: flux differences per direction
  always_ff @(posedge clk) begin
    s3_dx <= PDW'(s2_fe) - PDW'(s2_fw);
    s3_dy <= PDW'(s2_fn) - PDW'(s2_fs);
    s3_base <= s2_base;
    s3_old3 <= s2_old3;
    s3_old <= s2_old;
    s3_stage <= s2_stage;
  end

  // stage 4: total flux difference
  always_ff @(posedge clk) begin
    s4_diff <= DFW'(s3_dx) + DFW'(s3_dy);
    s4_base <= s3_base;
    s4_old3 <= s3_old3;
    s4_old <= s3_old;
    s4_stage <= s3_stage;
  end

  // stage 5: ratio times flux, as two partial products
  assign diff_lo = s4_diff[LO_BITS-1:0];
  assign diff_hi = s4_diff[DFW-1:LO_BITS];

  always_ff @(posedge clk) begin
    s5_pl <= diff_lo * step_ratio;
    s5_ph <= diff_hi * $signed({1'b0, step_ratio});
    s5_base <= s4_base;
    s5_old3 <= s4_old3;
    s5_old <= s4_old;
    s5_stage <= s4_stage;
  end

  // stage 6: combine partial products
  always_ff @(posedge clk) begin
    s6_prod <= (PW'(s5_ph) <<< LO_BITS) + PW'($signed({1'b0, s5_pl}));
    s6_base <= s5_base;
    s6_old3 <= s5_old3;
    s6_old <= s5_old;
    s6_stage <= s5_stage;
  end

  // stage 7: inner stage value, scaled by 2^RATIO_SHIFT
  always_ff @(posedge clk) begin
    s7_inner <= (IW'(s6_base) <<< RS) - IW'(s6_prod);
    s7_old3 <= s6_old3;
    s7_old <= s6_old;
    s7_stage <= s6_stage;
  end

  // stage 8: runge-kutta weighting with rounding offset, then scale down
  assign n0 = SW'(s7_inner) + RND_S0;
  assign n1 = (SW'(s7_old3) <<< RS) + SW'(s7_inner) + RND_S1;
  assign n2 = (SW'(s7_old) <<< (RS + 1)) + (SW'(s7_inner) <<< 2) + RND_S2;

  always_comb begin
    case (s7_stage)
      fvadv_pkg::RK_STAGE_ONE: begin
        q_sel = QW'(n1 >>> (RS + 2));
        div_sel = 1'b0;
      end
      fvadv_pkg::RK_STAGE_TWO: begin
        q_sel = QW'(n2 >>> (RS + 1));
        div_sel = 1'b1;
      end
      default: begin
        q_sel = QW'(n0 >>> RS);
        div_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s8_q <= q_sel;
    s8_div <= div_sel;
  end

  // third-stage weight needs a floor divide by three
  assign div_ctl.valid = pipe_valid[7];
  assign div_ctl.use_div = s8_div;

  fvadv_div3 u_div3 (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (div_ctl),
    .dividend  (s8_q),
    .res_valid (div_valid),
    .result    (div_res)
  );

  // saturate to the value range and register the result beat
  always_ff @(posedge clk) begin
    if (div_res > QW'(VAL_MAX)) begin
      update.u_next <= VAL_MAX;
      update.saturated <= 1'b1;
    end else if (div_res < QW'(VAL_MIN)) begin
      update.u_next <= VAL_MIN;
      update.saturated <= 1'b1;
    end else begin
      update.u_next <= div_res[V-1:0];
      update.saturated <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  `ASSERT_IMPLY(a_fixed_latency, clk, rst, done, $past(accept, LATENCY))
  `ASSERT_IMPLY(a_sat_at_limit, clk, rst, done && update.saturated, update.u_next == VAL_MAX || update.u_next == VAL_MIN)
  `ASSERT_IMPLY(a_busy_after_reset, clk, rst, busy, $past(rst))

endmodule

// ----- rtl/fvadv_div3.sv -----
`include "assert_macros.svh"

module fvadv_div3 (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fvadv_pkg::div_ctl_t                   ctl_in,
  input  logic signed [fvadv_pkg::QUO_BITS-1:0] dividend,
  output logic                                  res_valid,
  output logic signed [fvadv_pkg::QUO_BITS-1:0] result
);

  localparam int QW = fvadv_pkg::QUO_BITS;
  localparam int NY = QW + 1;
  localparam int S = fvadv_pkg::DIV_STAGES;
  localparam int DPS = fvadv_pkg::DIGITS_PER_STAGE;
  localparam int NYP = DPS * S;
  // bias of three times half the range keeps the dividend non-negative
  localparam logic [NY-1:0] BIAS = NY'(3) << (QW - 1);
  localparam logic [QW-1:0] UNBIAS = QW'(1) << (QW - 1);

  logic [NY-1:0]     biased;
  logic [S:0]        vld;
  logic [S:0]        udiv;
  logic [NYP-1:0]    vec [S+1];
  logic [1:0]        rem [S+1];
  logic [QW-1:0]     pass [S+1];
  logic [NYP-1:0]    vec_next [S];
  logic [1:0]        rem_next [S];

  assign biased = NY'(dividend) + BIAS;

  // long division by three, one chunk of dividend bits per stage,
  // quotient bits replace dividend bits in place
  always_comb begin
    logic [NYP-1:0] v;
    logic [1:0]     r;
    logic [2:0]     cur;
    for (int j = 0; j < S; j++) begin
      v = vec[j];
      r = rem[j];
      for (int k = 0; k < DPS; k++) begin
        cur = {r, v[NYP-1-DPS*j-k]};
        if (cur >= 3'd3) begin
          v[NYP-1-DPS*j-k] = 1'b1;
          r = 2'(cur - 3'd3);
        end else begin
          v[NYP-1-DPS*j-k] = 1'b0;
          r = cur[1:0];
        end
      end
      vec_next[j] = v;
      rem_next[j] = r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      res_valid <= 1'b0;
    end else begin
      vld <= {vld[S-1:0], ctl_in.valid};
      res_valid <= vld[S];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    vec[0] <= NYP'(biased);
    rem[0] <= 2'd0;
    pass[0] <= dividend;
    udiv[0] <= ctl_in.use_div;
    for (int j = 0; j < S; j++) begin
      vec[j+1] <= vec_next[j];
      rem[j+1] <= rem_next[j];
      pass[j+1] <= pass[j];
      udiv[j+1] <= udiv[j];
    end
  end

  // remove the bias from the quotient, or pass the value through
  always_ff @(posedge clk) begin
    if (udiv[S]) begin
      result <= QW'(vec[S]) - UNBIAS;
    end else begin
      result <= pass[S];
    end
  end

  `ASSERT_NEVER(a_rem_range, clk, rst, vld[S] && rem[S] == 2'd3)
  `ASSERT_IMPLY(a_div_latency, clk, rst, res_valid, $past(ctl_in.valid, S + 2))
  `ASSERT_NEVER(a_valid_known, clk, rst, $isunknown(vld))

endmodule

// ----- sim/fv_advection_cell_update_core_tb.sv -----
module fv_advection_cell_update_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0]                     wide_t;
  typedef logic signed [fvadv_pkg::VALUE_BITS-1:0] value_t;
  typedef logic [fvadv_pkg::RATIO_BITS-1:0]        ratio_t;
  typedef logic [fvadv_pkg::ORDER_BITS-1:0]        order_t;
  typedef logic [fvadv_pkg::STAGE_BITS-1:0]        stage_t;

  localparam int    VB               = fvadv_pkg::VALUE_BITS;
  localparam int    RSH              = fvadv_pkg::RATIO_SHIFT;
  localparam int    SETTLE_CYCLES    = 24;
  localparam int    CYCLE_LIMIT      = 400000;
  localparam int    RANDOM_PER_BLOCK = 155;

  localparam wide_t W_ONE   = 1;
  localparam wide_t VAL_MAX = (W_ONE <<< (VB - 1)) - 1;
  localparam wide_t VAL_MIN = -(W_ONE <<< (VB - 1));

  localparam value_t VALUE_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VB-1){1'b0}}};
  localparam value_t Q_ONE     = value_t'(1) <<< (VB - 4);

  localparam ratio_t RATIO_UNIT = fvadv_pkg::RATIO_BITS'(1) << (fvadv_pkg::RATIO_BITS - 1);
  localparam ratio_t RATIO_FULL = '1;

  // codes the package leaves unnamed, and the reset order under a second name
  localparam stage_t RK_STAGE_ZERO  = 2'd0;
  localparam stage_t RK_STAGE_SPARE = 2'd3;
  localparam order_t ORDER_SECOND   = fvadv_pkg::ORDER_RESET;
  localparam order_t ORDER_SPARE_LO = 2'd0;
  localparam order_t ORDER_SPARE_HI = 2'd3;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 start;
  logic                                 busy;
  fvadv_pkg::stencil_t                  stencil;
  logic                                 done;
  fvadv_pkg::update_t                   update;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [fvadv_pkg::INDEX_BITS-1:0]     cfg_index;
  ratio_t                               cfg_data;

  // local copy of the block's registers
  ratio_t ratio_setting = fvadv_pkg::RATIO_RESET;
  order_t order_setting = fvadv_pkg::ORDER_RESET;

  fvadv_pkg::update_t pending_updates[$];
  fvadv_pkg::update_t expected;
  int      idle_pct       = 0;
  int      error_count    = 0;
  int      accepted_count = 0;
  int      checked_count  = 0;
  int      clipped_count  = 0;
  int      cycle_count    = 0;

  fv_advection_cell_update_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .stencil   (stencil),
    .done      (done),
    .update    (update),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // minmod of the backward and forward differences
  function automatic wide_t limited_slope(wide_t back, wide_t fwd);
    if (back == 0 || fwd == 0 || ((back < 0) != (fwd < 0))) return '0;
    if (back < 0) return (back < fwd) ? fwd : back;
    return (back < fwd) ? back : fwd;
  endfunction

  // upwind face state, in half-lsb units
  function automatic wide_t face_twice(wide_t up2, wide_t up1, wide_t down, bit linear);
    wide_t f;
    f = up1 + up1;
    if (linear) f = f + limited_slope(up1 - up2, down - up1);
    return f;
  endfunction

  // exact cell update with one final rounding and saturation
  function automatic fvadv_pkg::update_t predict_update(fvadv_pkg::stencil_t s);
    wide_t   uw2, uw1, uc, ue1, us2, us1, un1, uold, src;
    wide_t   ratio, diff, inner, oldw, acc, res;
    bit      linear;
    fvadv_pkg::update_t u;
    uw2   = $signed(s.u_west2);
    uw1   = $signed(s.u_west1);
    uc    = $signed(s.u_center);
    ue1   = $signed(s.u_east1);
    us2   = $signed(s.u_south2);
    us1   = $signed(s.u_south1);
    un1   = $signed(s.u_north1);
    uold  = $signed(s.u_step_start);
    src   = $signed(s.source_dt);
    ratio = '0;
    ratio[fvadv_pkg::RATIO_BITS-1:0] = ratio_setting;
    linear = (order_setting != fvadv_pkg::ORDER_FIRST);

    diff = face_twice(uw1, uc, ue1, linear) - face_twice(uw2, uw1, uc, linear)
         + face_twice(us1, uc, un1, linear) - face_twice(us2, us1, uc, linear);
    // inner and old value in units of 2^-RATIO_SHIFT lsb
    inner = ((uc + src) <<< RSH) - diff * ratio;
    oldw  = uold <<< RSH;

    case (s.stage)
      fvadv_pkg::RK_STAGE_ONE: begin
        acc = 3 * oldw + inner;
        res = (acc + (W_ONE <<< (RSH + 1))) >>> (RSH + 2);
      end
      fvadv_pkg::RK_STAGE_TWO: begin
        acc = oldw + 2 * inner;
        acc = (2 * acc + 3 * (W_ONE <<< RSH)) >>> (RSH + 1);
        res = acc / 3;
        if (res * 3 > acc) res = res - 1;
      end
      default: begin
        // stage zero and the spare code share weights 0 and 1
        res = (inner + (W_ONE <<< (RSH - 1))) >>> RSH;
      end
    endcase

    u.saturated = 1'b0;
    if (res > VAL_MAX) begin
      res = VAL_MAX;
      u.saturated = 1'b1;
    end else if (res < VAL_MIN) begin
      res = VAL_MIN;
      u.saturated = 1'b1;
    end
    u.u_next = res[VB-1:0];
    return u;
  endfunction

  // result check, then capture of the stencil beat taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_updates.size() == 0) begin
          $error("result beat with no stencil outstanding: u_next %0d", update.u_next);
          error_count++;
        end else begin
          expected = pending_updates.pop_front();
          if (update.u_next !== expected.u_next) begin
            $error("u_next: expected %0d, got %0d", expected.u_next, update.u_next);
            error_count++;
          end
          if (update.saturated !== expected.saturated) begin
            $error("saturated: expected %0b, got %0b", expected.saturated, update.saturated);
            error_count++;
          end
          checked_count++;
          if (expected.saturated) clipped_count++;
        end
      end
      if (start && !busy) begin
        pending_updates.push_back(predict_update(stencil));
        accepted_count++;
      end
    end
  end

  // one stencil beat; entered and left at a falling edge
  task automatic send_stencil(fvadv_pkg::stencil_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    stencil = s;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // wait until every outstanding result has come back and the pipe is empty
  task automatic drain_updates();
    start = 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, only with the pipe empty
  task automatic write_reg(fvadv_pkg::reg_index_t idx, ratio_t data);
    drain_updates();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fvadv_pkg::REG_STEP_RATIO:   ratio_setting = data;
      fvadv_pkg::REG_SCHEME_ORDER: order_setting = data[fvadv_pkg::ORDER_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic fvadv_pkg::stencil_t make_stencil(value_t w2, value_t w1, value_t c,
                                                       value_t e1, value_t s2, value_t s1,
                                                       value_t n1, value_t old, value_t src,
                                                       stage_t stg);
    fvadv_pkg::stencil_t s;
    s.u_west2      = w2;
    s.u_west1      = w1;
    s.u_center     = c;
    s.u_east1      = e1;
    s.u_south2     = s2;
    s.u_south1     = s1;
    s.u_north1     = n1;
    s.u_step_start = old;
    s.source_dt    = src;
    s.stage        = stg;
    return s;
  endfunction

  // neighbor value: mostly close to base, sometimes flat, extreme or free
  function automatic value_t near_value(value_t base, int unsigned spread);
    value_t delta;
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      1, 2:    return base;
      3:       return value_t'($urandom);
      default: begin
        delta = $urandom & ((32'd1 << spread) - 1);
        return $urandom_range(0, 1) ? base + delta : base - delta;
      end
    endcase
  endfunction

  function automatic fvadv_pkg::stencil_t random_stencil();
    value_t              base;
    int unsigned         spread;
    fvadv_pkg::stencil_t s;
    base   = $urandom;
    spread = $urandom_range(0, VB - 2);
    s.u_west2      = near_value(base, spread);
    s.u_west1      = near_value(base, spread);
    s.u_center     = near_value(base, spread);
    s.u_east1      = near_value(base, spread);
    s.u_south2     = near_value(base, spread);
    s.u_south1     = near_value(base, spread);
    s.u_north1     = near_value(base, spread);
    s.u_step_start = near_value(base, spread);
    s.source_dt    = near_value('0, spread);
    s.stage = ($urandom_range(0, 9) == 0) ? RK_STAGE_SPARE
                                          : fvadv_pkg::STAGE_BITS'($urandom_range(0, 2));
    return s;
  endfunction

  // reset register values on flat, ramp and peak stencils
  task automatic test_reset_defaults();
    idle_pct = 0;
    send_stencil(make_stencil('0, '0, '0, '0, '0, '0, '0, '0, '0, RK_STAGE_ZERO));
    send_stencil(make_stencil(-2 * Q_ONE, -Q_ONE, '0, Q_ONE, -2 * Q_ONE, -Q_ONE, Q_ONE,
                              '0, '0, RK_STAGE_ZERO));
    send_stencil(make_stencil('0, '0, Q_ONE, '0, '0, '0, '0, '0, Q_ONE / 8, RK_STAGE_ZERO));
    drain_updates();
  endtask

  // clipping at both ends, with extreme fields
  task automatic test_saturation();
    idle_pct = 0;
    send_stencil(make_stencil(VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX,
                              VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, RK_STAGE_ZERO));
    send_stencil(make_stencil(VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN,
                              VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, RK_STAGE_ZERO));
    send_stencil(make_stencil(VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX, VALUE_MIN,
                              VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX,
                              fvadv_pkg::RK_STAGE_ONE));
    send_stencil(make_stencil(VALUE_MAX, VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX,
                              VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN,
                              fvadv_pkg::RK_STAGE_TWO));
    drain_updates();
  endtask

  // same stencil through every runge-kutta stage code, spare included
  task automatic test_stage_weights();
    fvadv_pkg::stencil_t s;
    s = make_stencil(-Q_ONE, -(Q_ONE / 3), Q_ONE / 7, Q_ONE / 2, Q_ONE, Q_ONE / 2 + 5,
                     -(Q_ONE / 4), Q_ONE + 3, -17, RK_STAGE_ZERO);
    idle_pct = 0;
    send_stencil(s);
    s.stage = fvadv_pkg::RK_STAGE_ONE;
    send_stencil(s);
    s.stage = fvadv_pkg::RK_STAGE_TWO;
    send_stencil(s);
    s.stage = RK_STAGE_SPARE;
    send_stencil(s);
    drain_updates();
  endtask

  // first order with later stages, and the unused order codes
  task automatic test_scheme_orders();
    fvadv_pkg::stencil_t s;
    s = make_stencil(Q_ONE / 5, Q_ONE / 2, Q_ONE, 2 * Q_ONE, -Q_ONE, Q_ONE / 3, Q_ONE + 1,
                     Q_ONE / 9, Q_ONE / 16, fvadv_pkg::RK_STAGE_TWO);
    idle_pct = 0;
    write_reg(fvadv_pkg::REG_SCHEME_ORDER, ratio_t'(fvadv_pkg::ORDER_FIRST));
    send_stencil(s);
    s.stage = fvadv_pkg::RK_STAGE_ONE;
    send_stencil(s);
    write_reg(fvadv_pkg::REG_SCHEME_ORDER, ratio_t'(ORDER_SPARE_LO));
    send_stencil(s);
    write_reg(fvadv_pkg::REG_SCHEME_ORDER, ratio_t'(ORDER_SPARE_HI));
    send_stencil(s);
    write_reg(fvadv_pkg::REG_SCHEME_ORDER, ratio_t'(ORDER_SECOND));
    drain_updates();
  endtask

  // zero ratio, unit ratio and ratio above one
  task automatic test_ratio_range();
    fvadv_pkg::stencil_t s;
    s = make_stencil(-3 * Q_ONE, -Q_ONE, Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE, -2 * Q_ONE,
                     Q_ONE / 2, -(Q_ONE / 3), RK_STAGE_ZERO);
    idle_pct = 0;
    write_reg(fvadv_pkg::REG_STEP_RATIO, '0);
    send_stencil(s);
    write_reg(fvadv_pkg::REG_STEP_RATIO, RATIO_UNIT);
    send_stencil(s);
    write_reg(fvadv_pkg::REG_STEP_RATIO, RATIO_FULL);
    send_stencil(s);
    s.stage = fvadv_pkg::RK_STAGE_TWO;
    send_stencil(s);
    write_reg(fvadv_pkg::REG_STEP_RATIO, fvadv_pkg::RATIO_RESET);
    drain_updates();
  endtask

  // random stencils over register settings and sender gap rates
  task automatic test_random_sweep();
    int     idle_phase[3] = '{0, 49, 30};
    order_t orders[4] = '{ORDER_SECOND, fvadv_pkg::ORDER_FIRST, ORDER_SPARE_LO,
                          ORDER_SPARE_HI};
    ratio_t ratio;
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 4; k++) begin
        case (k % 3)
          0: ratio = ratio_t'($urandom_range(0, RATIO_UNIT));
          1: begin
            case ($urandom_range(0, 2))
              0:       ratio = '0;
              1:       ratio = RATIO_UNIT;
              default: ratio = RATIO_FULL;
            endcase
          end
          default: ratio = ratio_t'($urandom_range(0, RATIO_FULL));
        endcase
        write_reg(fvadv_pkg::REG_STEP_RATIO, ratio);
        write_reg(fvadv_pkg::REG_SCHEME_ORDER, ratio_t'(orders[(p + k) % 4]));
        idle_pct = idle_phase[p];
        repeat (RANDOM_PER_BLOCK) send_stencil(random_stencil());
        drain_updates();
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    stencil   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_saturation();
    test_stage_weights();
    test_scheme_orders();
    test_ratio_range();
    test_random_sweep();
    drain_updates();

    $display("tb: %0d stencils in, %0d results checked, %0d clipped, %0d mismatches",
             accepted_count, checked_count, clipped_count, error_count);
    $display("tb: stages 0-3, scheme orders 0-3, step ratios 0 to above one, gaps 0/30/49 pct");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- fv_advection_cell_update_core.f -----
+incdir+rtl
rtl/fvadv_pkg.sv
rtl/fvadv_div3.sv
rtl/fv_advection_cell_update_core.sv
sim/fv_advection_cell_update_core_tb.sv
